// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define IDV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition holds whenever a trigger holds.
`define IDV_ASSERT_IMP(lbl, trig, cond, msg) \
  `IDV_ASSERT(lbl, (trig) |-> (cond), msg)

`endif

// ===== design/idv_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer divider package
// Word width, operation kinds, sequencer states and the control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package idv_pkg;

  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(WORD_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

  typedef enum logic [1:0] {
    KIND_UDIV = 2'd0,
    KIND_SDIV = 2'd1,
    KIND_UREM = 2'd2,
    KIND_SREM = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } idv_ctl_t;

endpackage

`default_nettype wire

// ===== design/idv_seq.sv =====
// ----------------------------------------------------------------------------
// Integer divider sequencer
// Runs one transaction through load, the shift-subtract steps and sign fix-up.
// ----------------------------------------------------------------------------
`default_nettype none

module idv_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output idv_pkg::idv_ctl_t ctl_o
);
  import idv_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             can_write;

  assign can_write = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (can_write) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    ctl_o.load   = in_valid_i && (state_q == ST_IDLE);
    ctl_o.step   = (state_q == ST_DIV);
    ctl_o.finish = (state_q == ST_FIX) && can_write;
    out_valid_d  = out_valid_q;
    if (ctl_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    out_valid_o  = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/idv_unit.sv =====
// ----------------------------------------------------------------------------
// Integer divider arithmetic unit
// Magnitude capture, one restoring shift-subtract step per cycle, sign fix-up.
// ----------------------------------------------------------------------------
`default_nettype none

module idv_unit (
  input  logic                            clk_i,
  input  idv_pkg::idv_ctl_t               ctl_i,
  input  logic [1:0]                      kind_i,
  input  logic [idv_pkg::WORD_WIDTH-1:0]  dividend_i,
  input  logic [idv_pkg::WORD_WIDTH-1:0]  divisor_i,
  output logic [idv_pkg::WORD_WIDTH-1:0]  result_o,
  output logic                            divide_by_zero_o
);
  import idv_pkg::*;

  logic [WORD_WIDTH-1:0] rem_q, rem_d, quo_q, quo_d, div_q, div_d;
  logic                  neg_a_q, neg_a_d, neg_quo_q, neg_quo_d;
  logic                  want_rem_q, want_rem_d, zero_q, zero_d;
  logic [WORD_WIDTH-1:0] result_q, result_d;
  logic                  dbz_q, dbz_d;

  logic                  is_signed, neg_a, neg_b;
  logic [WORD_WIDTH:0]   rem_sh;
  logic [WORD_WIDTH+1:0] diff;
  logic [WORD_WIDTH-1:0] rem_fix, quo_fix;

  always_comb begin
    is_signed  = 1'b0;
    want_rem_d = want_rem_q;
    unique case (kind_e'(kind_i))
      KIND_UDIV: begin
        is_signed = 1'b0;
      end
      KIND_SDIV: begin
        is_signed = 1'b1;
      end
      KIND_UREM: begin
        is_signed = 1'b0;
      end
      KIND_SREM: begin
        is_signed = 1'b1;
      end
      default: begin
        is_signed = 1'b0;
      end
    endcase
    neg_a = is_signed && dividend_i[WORD_WIDTH-1];
    neg_b = is_signed && divisor_i[WORD_WIDTH-1];

    rem_sh = {rem_q, quo_q[WORD_WIDTH-1]};
    diff   = {1'b0, rem_sh} - {2'b00, div_q};

    rem_d     = rem_q;
    quo_d     = quo_q;
    div_d     = div_q;
    neg_a_d   = neg_a_q;
    neg_quo_d = neg_quo_q;
    zero_d    = zero_q;

    if (ctl_i.load) begin
      rem_d      = '0;
      quo_d      = neg_a ? (~dividend_i + WORD_WIDTH'(1)) : dividend_i;
      div_d      = neg_b ? (~divisor_i + WORD_WIDTH'(1)) : divisor_i;
      neg_a_d    = neg_a;
      neg_quo_d  = neg_a ^ neg_b;
      zero_d     = (divisor_i == '0);
      want_rem_d = (kind_e'(kind_i) == KIND_UREM) || (kind_e'(kind_i) == KIND_SREM);
    end else if (ctl_i.step) begin
      if (!diff[WORD_WIDTH+1]) begin
        rem_d = diff[WORD_WIDTH-1:0];
        quo_d = {quo_q[WORD_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[WORD_WIDTH-1:0];
        quo_d = {quo_q[WORD_WIDTH-2:0], 1'b0};
      end
    end

    rem_fix = neg_a_q ? (~rem_q + WORD_WIDTH'(1)) : rem_q;
    if (zero_q) begin
      quo_fix = '1;
    end else begin
      quo_fix = neg_quo_q ? (~quo_q + WORD_WIDTH'(1)) : quo_q;
    end

    result_d = result_q;
    dbz_d    = dbz_q;
    if (ctl_i.finish) begin
      result_d = want_rem_q ? rem_fix : quo_fix;
      dbz_d    = zero_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    div_q      <= div_d;
    neg_a_q    <= neg_a_d;
    neg_quo_q  <= neg_quo_d;
    want_rem_q <= want_rem_d;
    zero_q     <= zero_d;
    result_q   <= result_d;
    dbz_q      <= dbz_d;
  end

  assign result_o         = result_q;
  assign divide_by_zero_o = dbz_q;

endmodule

`default_nettype wire

// ===== design/integer_divider_signed_unsigned_core.sv =====
// ----------------------------------------------------------------------------
// Signed and unsigned integer divider
// Quotient or remainder of two 32-bit words by restoring shift-subtract.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries kind_i, dividend_i and divisor_i under
// in_valid_i/in_ready_o; the output channel carries result_o and
// divide_by_zero_o under out_valid_o/out_ready_i.
// An accepted transaction then runs the shift-subtract steps on the shared
// subtractor, one quotient bit per cycle, and then a sign fix-up step.
// The block takes one transaction at a time.
// Signed quotients truncate toward zero and signed remainders follow the
// dividend's sign. A zero divisor gives an all-ones quotient or the dividend
// as remainder, with divide_by_zero_o set.
// The result is held in an output register; while the receiver stalls the
// next transaction may still be accepted and computed, and it waits in the
// fix-up step until the register is free.
// Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_divider_signed_unsigned_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [idv_pkg::WORD_WIDTH-1:0] dividend_i,
  input  logic [idv_pkg::WORD_WIDTH-1:0] divisor_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [idv_pkg::WORD_WIDTH-1:0] result_o,
  output logic                           divide_by_zero_o
);
  import idv_pkg::*;

  idv_ctl_t ctl;

  idv_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  idv_unit u_unit (
    .clk_i            (clk_i),
    .ctl_i            (ctl),
    .kind_i           (kind_i),
    .dividend_i       (dividend_i),
    .divisor_i        (divisor_i),
    .result_o         (result_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

`include "assert_macros.svh"

  `IDV_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `IDV_ASSERT(a_load_then_step, ctl.load |=> ctl.step, "no step after load")
  `IDV_ASSERT_IMP(a_valid_from_finish, $rose(out_valid_o), $past(ctl.finish), "stray valid")

endmodule

`default_nettype wire

// ===== verif/tb_integer_divider_signed_unsigned_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the signed and unsigned integer divider
// Drives kind, dividend and divisor transactions through a valid/ready driver,
// predicts each quotient or remainder with an independent model and checks
// every result in order. A directed set of corner cases comes first, followed
// by random operands, random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_integer_divider_signed_unsigned_core;

  import idv_pkg::*;

  localparam int unsigned W              = idv_pkg::WORD_WIDTH;
  localparam int          RANDOM_ITEMS   = 850;
  localparam int          LIMIT_CYCLES   = 600000;
  localparam int          PRESSURE_START = 3000;
  localparam int          PRESSURE_LEN   = 400;
  localparam int          DRAIN_CYCLES   = 80;

  typedef logic [W-1:0] word_t;

  localparam word_t MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam word_t MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam word_t ALL_ONES = '1;

  typedef struct {
    kind_e kind;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct {
    word_t result;
    logic  divide_by_zero;
  } div_res_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [1:0] kind_i      = '0;
  word_t      dividend_i  = '0;
  word_t      divisor_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  word_t      result_o;
  logic       divide_by_zero_o;

  div_req_t operand_queue[$];
  div_res_t due_results[$];

  int errors        = 0;
  int cycle_count   = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int zero_div_count = 0;
  int wrap_count    = 0;
  int kind_count[4] = '{0, 0, 0, 0};

  kind_e all_kinds[4] = '{KIND_UDIV, KIND_SDIV, KIND_UREM, KIND_SREM};

  integer_divider_signed_unsigned_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .dividend_i       (dividend_i),
    .divisor_i        (divisor_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_o         (result_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic div_res_t divide_word(div_req_t req);
    div_res_t res;
    logic     is_signed;
    logic     want_rem;
    logic     neg_a;
    logic     neg_b;
    word_t    ua;
    word_t    ub;
    word_t    r;
    is_signed = (req.kind == KIND_SDIV) || (req.kind == KIND_SREM);
    want_rem  = (req.kind == KIND_UREM) || (req.kind == KIND_SREM);
    res.divide_by_zero = 1'b0;
    if (req.divisor == '0) begin
      res.divide_by_zero = 1'b1;
      res.result = want_rem ? req.dividend : ALL_ONES;
    end else begin
      neg_a = is_signed && req.dividend[W-1];
      neg_b = is_signed && req.divisor[W-1];
      ua = neg_a ? word_t'(-req.dividend) : req.dividend;
      ub = neg_b ? word_t'(-req.divisor) : req.divisor;
      if (want_rem) begin
        r = ua % ub;
        if (neg_a) r = word_t'(-r);
      end else begin
        r = ua / ub;
        if (neg_a != neg_b) r = word_t'(-r);
      end
      res.result = r;
    end
    return res;
  endfunction

  function automatic word_t random_operand();
    word_t v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 15);
      1: v = word_t'(-$urandom_range(1, 15));
      2: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = word_t'(1);
          2: v = MOST_NEG;
          3: v = MOST_POS;
          default: v = ALL_ONES;
        endcase
      end
      3: v = word_t'($urandom) >> $urandom_range(0, W - 1);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 60);
  endfunction

  // Driver: presents queued transactions and records each accepted one.
  div_req_t tx_item;
  int       tx_gap = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        due_results.push_back(divide_word(tx_item));
        sent_count++;
        kind_count[tx_item.kind]++;
        if (tx_item.divisor == '0) zero_div_count++;
        if (tx_item.dividend == MOST_NEG && tx_item.divisor == ALL_ONES) wrap_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (operand_queue.size() > 0) begin
          tx_item = operand_queue.pop_front();
          in_valid_i <= 1'b1;
          kind_i     <= tx_item.kind;
          dividend_i <= tx_item.dividend;
          divisor_i  <= tx_item.divisor;
          tx_gap = (cycle_count > 12000 && cycle_count < 16000) ? 0 : idle_length();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off that fills the block.
  int rx_hold = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (cycle_count == PRESSURE_START) begin
      out_ready_i <= 1'b0;
      rx_hold = PRESSURE_LEN;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if ((cycle_count > 12000 && cycle_count < 16000) ||
                 $urandom_range(0, 99) < 70) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      rx_hold = idle_length();
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    div_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result %h divide_by_zero %b", $time, result_o,
                 divide_by_zero_o);
        errors++;
      end else begin
        want = due_results.pop_front();
        checked_count++;
        if (result_o !== want.result) begin
          $display("%0t: result mismatch, expected %h actual %h", $time, want.result,
                   result_o);
          errors++;
        end
        if (divide_by_zero_o !== want.divide_by_zero) begin
          $display("%0t: divide_by_zero mismatch, expected %b actual %b", $time,
                   want.divide_by_zero, divide_by_zero_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
      $display("FAIL integer_divider_signed_unsigned_core");
      $finish;
    end
  end

  initial begin
    div_req_t req;
    word_t    pairs[6][2];
    pairs[0] = '{32'hDEAD_BEEF, '0};
    pairs[1] = '{MOST_NEG, ALL_ONES};
    pairs[2] = '{ALL_ONES, word_t'(1)};
    pairs[3] = '{word_t'(-7), word_t'(2)};
    pairs[4] = '{word_t'(7), word_t'(-2)};
    pairs[5] = '{MOST_POS, MOST_NEG};
    foreach (all_kinds[k]) begin
      foreach (pairs[p]) begin
        req.kind     = all_kinds[k];
        req.dividend = pairs[p][0];
        req.divisor  = pairs[p][1];
        operand_queue.push_back(req);
      end
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      req.kind     = all_kinds[$urandom_range(0, 3)];
      req.dividend = random_operand();
      req.divisor  = ($urandom_range(0, 29) == 0) ? word_t'(0) : random_operand();
      operand_queue.push_back(req);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (operand_queue.size() != 0 || in_valid_i || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Checked %0d results from %0d transactions in %0d cycles, %0d errors.",
             checked_count, sent_count, cycle_count, errors);
    $display("Kinds udiv/sdiv/urem/srem: %0d/%0d/%0d/%0d; zero divisors %0d, wraps %0d.",
             kind_count[KIND_UDIV], kind_count[KIND_SDIV], kind_count[KIND_UREM],
             kind_count[KIND_SREM], zero_div_count, wrap_count);
    if (errors == 0 && due_results.size() == 0) begin
      $display("PASS integer_divider_signed_unsigned_core");
    end else begin
      $display("FAIL integer_divider_signed_unsigned_core");
    end
    $finish;
  end

endmodule
